>>> hw/rtl/gha_pkg.sv
package gha_pkg;

	localparam int IndexBitsDefault = 10;
	localparam int HandleWidth      = 31;
	localparam int SlotWidth        = 32;
	localparam int SlotNumWidth     = 10;

	typedef enum logic [2:0] {
		ACT_ALLOC      = 3'd0,
		ACT_RELEASE    = 3'd1,
		ACT_CHECK      = 3'd2,
		ACT_IMPORT_USE = 3'd3,
		ACT_IMPORT_FRE = 3'd4,
		ACT_NEXT_USED  = 3'd5,
		ACT_NEXT_FREE  = 3'd6,
		ACT_READ_SLOT  = 3'd7
	} action_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NONE     = 2'd1;
	localparam logic [1:0] ST_LARGER   = 2'd2;
	localparam logic [1:0] ST_CONFLICT = 2'd3;

	typedef struct packed {
		logic [2:0]              action;
		logic [HandleWidth-1:0]  handle_in;
		logic [SlotNumWidth-1:0] slot_number;
	} req_t;

	typedef struct packed {
		logic [HandleWidth-1:0] handle_out;
		logic [1:0]             status;
	} rsp_t;

endpackage

>>> hw/rtl/generational_handle_allocator_top.sv
// channel  | signals              | direction | handshake
// request  | start, busy, req     | in        | taken when start && !busy
// result   | done, rsp            | out       | one-cycle strobe, no backpressure
//
// after reset a clearing pass writes the initial free list, one slot a cycle, with busy
// high. Each request runs as a sequence of dependent reads and writes of the slot memory,
// which has one read port and one write port; check, read slot and any request that fails
// on its first read end after that read. import used walks the free list link by link,
// up to 2^INDEX_BITS links; next used scans the slots one after another.
// reset restarts the clearing pass; the receiver cannot stall results.
module generational_handle_allocator_top #(
	parameter int INDEX_BITS = gha_pkg::IndexBitsDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  gha_pkg::req_t req,
	output logic          done,
	output gha_pkg::rsp_t rsp
);
	import gha_pkg::*;

	localparam int N = 1 << INDEX_BITS;
	localparam logic [SlotWidth-1:0] IDX_MASK = SlotWidth'(N - 1);
	localparam logic [SlotWidth-1:0] USED = 32'h8000_0000;

	typedef logic [INDEX_BITS-1:0] idx_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD1, S_EV1, S_RD2, S_EV2, S_RD3, S_EV3, S_WR2, S_DONE
	} state_t;

	logic [SlotWidth-1:0] mem [N];
	logic [SlotWidth-1:0] rdata;
	logic                 we;
	idx_t                 waddr, raddr;
	logic [SlotWidth-1:0] wdata;
	logic                 re;

	state_t                 state_q;
	idx_t                   tail_q, ptr_q, prev_q, idx_q, wa2_q;
	logic [INDEX_BITS:0]    cnt_q;
	logic [2:0]             act_q;
	logic [HandleWidth-1:0] id_q;
	logic [SlotWidth-1:0]   v_q, wd2_q;
	rsp_t                   rsp_q;
	logic                   done_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

	function automatic logic [SlotWidth-1:0] hi(input logic [SlotWidth-1:0] x);
		return x & ~IDX_MASK;
	endfunction

	function automatic logic [SlotWidth-1:0] ext(input idx_t i);
		return SlotWidth'(i);
	endfunction

	// memory port control from the sequencer
	always_comb begin
		we = 1'b0; waddr = '0; wdata = '0; re = 1'b0; raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1; waddr = cnt_q[INDEX_BITS-1:0];
				wdata = (cnt_q[INDEX_BITS-1:0] == '0) ?
					(SlotWidth'(N) | 32'd1) : ext(cnt_q[INDEX_BITS-1:0] + idx_t'(1));
			end
			S_RD1, S_RD2, S_RD3: begin re = 1'b1; raddr = ptr_q; end
			S_WR2: begin we = 1'b1; waddr = wa2_q; wdata = wd2_q; end
			S_IDLE, S_EV1, S_EV2, S_EV3, S_DONE: ;
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	idx_t                   id_idx;
	logic [HandleWidth-1:0] id_bump;
	assign id_idx  = id_q[INDEX_BITS-1:0];
	assign id_bump = ((id_q + HandleWidth'(N)) == '0) ? HandleWidth'(N) :
		(id_q + HandleWidth'(N));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
			tail_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (INDEX_BITS+1)'(N - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						act_q <= req.action;
						id_q  <= req.handle_in;
						idx_q <= req.handle_in[INDEX_BITS-1:0];
						cnt_q <= '0;
						rsp_q <= '{handle_out: '0, status: ST_OK};
						state_q <= S_RD1;
						unique case (action_t'(req.action))
							ACT_ALLOC: ptr_q <= tail_q;
							ACT_NEXT_FREE: ptr_q <= (req.handle_in == '0) ? tail_q :
								req.handle_in[INDEX_BITS-1:0];
							ACT_READ_SLOT: ptr_q <= idx_t'(req.slot_number);
							ACT_NEXT_USED: begin
								ptr_q <= (req.handle_in == '0) ? idx_t'(0) :
									req.handle_in[INDEX_BITS-1:0] + idx_t'(1);
								cnt_q <= (req.handle_in == '0) ? '0 :
									{1'b0, req.handle_in[INDEX_BITS-1:0]} + 1'b1;
							end
							default: ptr_q <= req.handle_in[INDEX_BITS-1:0];
						endcase
					end
				end
				S_RD1: state_q <= S_EV1;
				S_EV1: begin
					v_q <= rdata;
					state_q <= S_DONE;
					unique case (action_t'(act_q))
						ACT_ALLOC: begin
							if (rdata[31]) rsp_q.status <= ST_NONE;
							else begin ptr_q <= rdata[INDEX_BITS-1:0]; state_q <= S_RD2; end
						end
						ACT_RELEASE: begin
							if (rdata != {1'b1, id_q}) rsp_q.status <= ST_NONE;
							else begin ptr_q <= tail_q; state_q <= S_RD2; end
						end
						ACT_CHECK: rsp_q.status <= (rdata == {1'b1, id_q}) ? ST_OK : ST_NONE;
						ACT_IMPORT_USE, ACT_IMPORT_FRE: begin
							if (rdata[31])
								rsp_q.status <= (rdata[30:0] < id_q) ? ST_LARGER : ST_CONFLICT;
							else if (act_q == ACT_IMPORT_FRE) begin
								if (hi({1'b0, id_q}) > hi(rdata)) begin
									wa2_q <= idx_q;
									wd2_q <= hi({1'b0, id_q}) | (rdata & IDX_MASK);
									state_q <= S_WR2;
								end
							end else begin
								ptr_q <= tail_q; prev_q <= tail_q;
								cnt_q <= '0; state_q <= S_RD3;
							end
						end
						ACT_NEXT_USED: begin
							// scan already ran past the last slot
							if (cnt_q[INDEX_BITS]) rsp_q.status <= ST_NONE;
							else if (rdata[31]) rsp_q.handle_out <= rdata[30:0];
							else if (cnt_q >= (INDEX_BITS+1)'(N - 1)) rsp_q.status <= ST_NONE;
							else begin
								ptr_q <= ptr_q + idx_t'(1);
								cnt_q <= cnt_q + 1'b1; state_q <= S_RD1;
							end
						end
						ACT_NEXT_FREE: begin
							if (rdata[31]) rsp_q.status <= ST_NONE;
							else if (id_q == '0) begin
								rsp_q.handle_out <= 31'(hi(rdata) | ext(tail_q));
								rsp_q.status <= ((31'(hi(rdata) | ext(tail_q))) == '0) ?
									ST_NONE : ST_OK;
							end else if (rdata[INDEX_BITS-1:0] == tail_q)
								rsp_q.status <= ST_NONE;
							else begin ptr_q <= rdata[INDEX_BITS-1:0]; state_q <= S_RD2; end
						end
						default: begin
							if (rdata[31]) rsp_q.handle_out <= rdata[30:0];
							else rsp_q.status <= ST_NONE;
						end
					endcase
				end
				S_RD2: state_q <= S_EV2;
				S_EV2: begin
					state_q <= S_WR2;
					unique case (action_t'(act_q))
						ACT_ALLOC: begin
							// relink tail past the taken slot first, then mark it used
							wa2_q <= tail_q;
							wd2_q <= hi(v_q) | ext(rdata[INDEX_BITS-1:0]);
							v_q <= USED | hi(rdata) | ext(ptr_q);
							rsp_q.handle_out <= 31'(hi(rdata) | ext(ptr_q));
						end
						ACT_RELEASE: begin
							tail_q <= idx_q;
							wa2_q <= idx_q;
							if (rdata[31]) wd2_q <= hi({1'b0, id_bump}) | ext(idx_q);
							else begin
								wd2_q <= hi({1'b0, id_bump}) | (rdata & IDX_MASK);
								prev_q <= ptr_q;
								v_q <= hi(rdata) | ext(idx_q);
							end
						end
						default: begin
							rsp_q.handle_out <= 31'(hi(rdata) | ext(ptr_q));
							rsp_q.status <= ((31'(hi(rdata) | ext(ptr_q))) == '0) ?
								ST_NONE : ST_OK;
							state_q <= S_DONE;
						end
					endcase
				end
				S_RD3: state_q <= S_EV3;
				S_EV3: begin
					// free list walk for import used
					if (rdata[INDEX_BITS-1:0] == idx_q) begin
						wa2_q <= ptr_q;
						wd2_q <= hi(rdata) | (v_q & IDX_MASK);
						if (tail_q == idx_q) tail_q <= ptr_q;
						prev_q <= ptr_q;
						state_q <= S_WR2;
					end else if (cnt_q == (INDEX_BITS+1)'(N - 1)) begin
						wa2_q <= idx_q; wd2_q <= {1'b1, id_q};
						act_q <= ACT_CHECK; state_q <= S_WR2;
					end else begin
						ptr_q <= rdata[INDEX_BITS-1:0];
						cnt_q <= cnt_q + 1'b1; state_q <= S_RD3;
					end
				end
				S_WR2: begin
					state_q <= S_DONE;
					unique case (action_t'(act_q))
						ACT_ALLOC: begin
							wa2_q <= ptr_q;
							wd2_q <= v_q;
							act_q <= ACT_CHECK; state_q <= S_WR2;
						end
						ACT_RELEASE: begin
							if (!v_q[31] && ptr_q != idx_q) begin
								wa2_q <= prev_q; wd2_q <= v_q;
								act_q <= ACT_CHECK; state_q <= S_WR2;
							end else if (!v_q[31]) begin
								wa2_q <= idx_q;
								wd2_q <= hi({1'b0, id_bump}) | ext(idx_q);
								act_q <= ACT_CHECK; state_q <= S_WR2;
							end
						end
						ACT_IMPORT_USE: begin
							wa2_q <= idx_q; wd2_q <= {1'b1, id_q};
							act_q <= ACT_CHECK; state_q <= S_WR2;
						end
						default: ;
					endcase
				end
				S_DONE: begin done_q <= 1'b1; state_q <= S_IDLE; end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result without return to idle");
	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !we) else $error("slot write while idle");
	a_rsp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (act_q == ACT_RELEASE)) |-> (rsp.handle_out == '0))
		else $error("release returned a handle");
`endif

endmodule

>>> bench/generational_handle_allocator_top_tb.sv
module generational_handle_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gha_pkg::*;

	localparam int IB = IndexBitsDefault;
	localparam int NSLOT = 1 << IB;
	localparam logic [31:0] IMASK = NSLOT - 1;
	localparam logic [31:0] USED = 32'h8000_0000;
	localparam logic [31:0] H31 = 32'h7FFF_FFFF;
	localparam int N_RANDOM = 1880;
	localparam int IDLE_LIMIT = 12000;

	typedef struct {
		action_t     act;
		logic [30:0] h;
		logic [9:0]  sn;
		bit          typed;
		logic [30:0] eh;
		logic [1:0]  es;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic done;
	req_t req = '0;
	rsp_t rsp;

	logic [31:0] slots [NSLOT];
	logic [31:0] tail;
	rsp_t pending_rsp [$];
	int errors = 0;
	int idle_cycles = 0;

	generational_handle_allocator_top #(.INDEX_BITS(IB)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	always #5 clk = ~clk;

	function automatic rsp_t mk(logic [31:0] h, logic [1:0] st);
		rsp_t r;
		r.handle_out = h[30:0];
		r.status = st;
		return r;
	endfunction

	function automatic void table_reset();
		for (int i = 0; i < NSLOT; i++) slots[i] = (i + 1) & IMASK;
		slots[0] = NSLOT | 1;
		tail = 0;
	endfunction

	// advances the table model by one item and returns what it should answer
	function automatic rsp_t apply_op(req_t r);
		logic [31:0] id, idx, v, nx, nv, prev;
		int i;
		bit found;
		id = {1'b0, r.handle_in};
		idx = id & IMASK;
		case (action_t'(r.action))
			ACT_ALLOC: begin
				v = slots[tail];
				if (v & USED) return mk(0, ST_NONE);
				nx = v & IMASK;
				nv = slots[nx];
				slots[tail] = (v & ~IMASK) | (nv & IMASK);
				v = ((nv & ~IMASK) | nx) & H31;
				slots[nx] = v | USED;
				return mk(v, ST_OK);
			end
			ACT_RELEASE: begin
				if (slots[idx] != (id | USED)) return mk(0, ST_NONE);
				id = (id + NSLOT) & H31;
				if (id == 0) id = NSLOT;
				v = slots[tail];
				if (v & USED) begin
					slots[idx] = (id & ~IMASK) | idx;
				end else begin
					nx = v & IMASK;
					slots[tail] = (v & ~IMASK) | idx;
					slots[idx] = (id & ~IMASK) | nx;
				end
				tail = idx;
				return mk(0, ST_OK);
			end
			ACT_CHECK: return mk(0, slots[idx] == (id | USED) ? ST_OK : ST_NONE);
			ACT_IMPORT_USE, ACT_IMPORT_FRE: begin
				v = slots[idx];
				if (v & USED) return mk(0, ((v & H31) < id) ? ST_LARGER : ST_CONFLICT);
				if (action_t'(r.action) == ACT_IMPORT_FRE) begin
					if ((id & ~IMASK) > (v & ~IMASK)) slots[idx] = (id & ~IMASK) | (v & IMASK);
				end else begin
					prev = tail;
					found = 0;
					for (i = 0; i < NSLOT; i++) begin
						nx = slots[prev] & IMASK;
						if (nx == idx) begin
							found = 1;
							break;
						end
						prev = nx;
					end
					if (found) begin
						slots[prev] = (slots[prev] & ~IMASK) | (v & IMASK);
						if (tail == idx) tail = prev;
					end
					slots[idx] = id | USED;
				end
				return mk(0, ST_OK);
			end
			ACT_NEXT_USED: begin
				for (i = (id == 0) ? 0 : idx + 1; i < NSLOT; i++)
					if (slots[i] & USED) return mk(slots[i] & H31, ST_OK);
				return mk(0, ST_NONE);
			end
			ACT_NEXT_FREE: begin
				if (id == 0) begin
					v = slots[tail];
					if (v & USED) return mk(0, ST_NONE);
					v = ((v & ~IMASK) | tail) & H31;
				end else begin
					v = slots[idx];
					if (v & USED) return mk(0, ST_NONE);
					nx = v & IMASK;
					if (nx == tail) return mk(0, ST_NONE);
					v = ((slots[nx] & ~IMASK) | nx) & H31;
				end
				return mk(v, v == 0 ? ST_NONE : ST_OK);
			end
			default: begin
				v = slots[r.slot_number & IMASK];
				return (v & USED) ? mk(v & H31, ST_OK) : mk(0, ST_NONE);
			end
		endcase
	endfunction

	// mostly handles that name real slots, the rest zero or raw noise
	function automatic logic [30:0] pick_handle(bit want_used);
		logic [31:0] idx, v;
		int k;
		k = $urandom_range(0, 9);
		if (k < 2) return 31'($urandom());
		if (k == 2) return '0;
		idx = $urandom_range(0, NSLOT - 1);
		if (k < 5) idx = $urandom_range(0, 63);
		v = slots[idx];
		if (want_used) return (v & USED) ? v[30:0] : 31'((v & ~IMASK) | idx);
		return 31'(((v & ~IMASK) | idx) & H31);
	endfunction

	function automatic req_t random_item(bit filling);
		req_t r;
		int k;
		r.slot_number = 10'($urandom());
		if ($urandom_range(0, 1)) r.slot_number = 10'($urandom_range(0, 63));
		k = $urandom_range(0, 99);
		if (filling) begin
			if (k < 84) k = 0;
			else k = $urandom_range(1, 7);
		end else begin
			k = (k < 30) ? 0 : (k < 60) ? 1 : $urandom_range(2, 7);
		end
		r.action = 3'(k);
		case (action_t'(r.action))
			ACT_IMPORT_FRE: r.handle_in = 31'({1'b0, pick_handle(0)} | ($urandom() & ~IMASK));
			ACT_IMPORT_USE: r.handle_in = 31'(($urandom() & ~IMASK) | $urandom_range(0, 255));
			ACT_NEXT_FREE: r.handle_in = pick_handle(0);
			default: r.handle_in = pick_handle(1);
		endcase
		return r;
	endfunction

	task automatic send(req_t r, bit typed, rsp_t typed_rsp);
		rsp_t p;
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		p = apply_op(r);
		pending_rsp.push_back(typed ? typed_rsp : p);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$error("result with no item outstanding: handle_out %h status %0d",
					rsp.handle_out, rsp.status);
				errors++;
			end else begin
				if (rsp.handle_out !== pending_rsp[0].handle_out) begin
					$error("handle_out expected %h actual %h", pending_rsp[0].handle_out,
						rsp.handle_out);
					errors++;
				end
				if (rsp.status !== pending_rsp[0].status) begin
					$error("status expected %0d actual %0d", pending_rsp[0].status, rsp.status);
					errors++;
				end
				void'(pending_rsp.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** generational_handle_allocator_top: FAILED **");
			$finish;
		end
	end

	row_t directed [] = '{
		'{ACT_ALLOC,      31'd0,          10'd0,    1, 31'd1,          ST_OK},
		'{ACT_READ_SLOT,  31'd0,          10'd0,    1, 31'd0,          ST_NONE},
		'{ACT_READ_SLOT,  31'd0,          10'd1,    1, 31'd1,          ST_OK},
		'{ACT_CHECK,      31'd0,          10'd0,    1, 31'd0,          ST_NONE},
		'{ACT_CHECK,      31'd1,          10'd0,    1, 31'd0,          ST_OK},
		'{ACT_RELEASE,    31'd0,          10'd0,    1, 31'd0,          ST_NONE},
		'{ACT_NEXT_USED,  31'd0,          10'd0,    1, 31'd1,          ST_OK},
		'{ACT_NEXT_USED,  31'd1,          10'd0,    1, 31'd0,          ST_NONE},
		'{ACT_NEXT_FREE,  31'd0,          10'd0,    0, 31'd0,          ST_OK},
		'{ACT_RELEASE,    31'd1,          10'd0,    1, 31'd0,          ST_OK},
		'{ACT_CHECK,      31'd1,          10'd0,    1, 31'd0,          ST_NONE},
		'{ACT_NEXT_FREE,  31'd1,          10'd0,    0, 31'd0,          ST_OK},
		'{ACT_ALLOC,      31'd0,          10'd0,    0, 31'd0,          ST_OK},
		'{ACT_IMPORT_USE, 31'h7FFF_FFFF,  10'd0,    1, 31'd0,          ST_OK},
		'{ACT_READ_SLOT,  31'd0,          10'h3FF,  1, 31'h7FFF_FFFF,  ST_OK},
		'{ACT_IMPORT_FRE, 31'h7FFF_FFFF,  10'd0,    1, 31'd0,          ST_CONFLICT},
		'{ACT_IMPORT_USE, 31'h0000_03FF,  10'd0,    1, 31'd0,          ST_CONFLICT},
		'{ACT_IMPORT_FRE, 31'h7FFF_FC05,  10'd0,    1, 31'd0,          ST_OK},
		'{ACT_NEXT_FREE,  31'd5,          10'd0,    0, 31'd0,          ST_OK},
		'{ACT_IMPORT_USE, 31'h7FFF_FC00,  10'd0,    1, 31'd0,          ST_OK},
		'{ACT_RELEASE,    31'h7FFF_FC00,  10'd0,    1, 31'd0,          ST_OK},
		'{ACT_READ_SLOT,  31'd0,          10'd0,    1, 31'd0,          ST_NONE},
		'{ACT_IMPORT_USE, 31'd0,          10'd0,    0, 31'd0,          ST_OK},
		'{ACT_NEXT_USED,  31'h7FFF_FFFF,  10'd0,    0, 31'd0,          ST_OK},
		'{ACT_RELEASE,    31'h7FFF_FFFF,  10'd0,    1, 31'd0,          ST_OK}
	};

	initial begin
		req_t r;
		table_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		foreach (directed[n]) begin
			r.action = directed[n].act;
			r.handle_in = directed[n].h;
			r.slot_number = directed[n].sn;
			send(r, directed[n].typed, mk({1'b0, directed[n].eh}, directed[n].es));
		end
		// fill toward a full table first, then churn
		for (int n = 0; n < N_RANDOM; n++)
			send(random_item(n < 1250), 0, '0);
		start <= 0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0) begin
			$display("** generational_handle_allocator_top: PASSED **");
		end else begin
			$display("** generational_handle_allocator_top: FAILED **");
		end
		$finish;
	end
endmodule

>>> generational_handle_allocator_top.f
hw/rtl/gha_pkg.sv
hw/rtl/generational_handle_allocator_top.sv
bench/generational_handle_allocator_top_tb.sv
